/* rtl/peak_envelope_noise_gate_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the peak envelope noise gate
// Clocked assertion helpers used by the controller of the block.
// ----------------------------------------------------------------------------
`ifndef PEAK_ENVELOPE_NOISE_GATE_TOP_ASSERT_SVH
`define PEAK_ENVELOPE_NOISE_GATE_TOP_ASSERT_SVH

// Checks a property on every rising edge of clk while reset is released.
`define PEGATE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define PEGATE_ASSERT_IMPL(label, cond, cons, msg) \
    `PEGATE_ASSERT(label, (cond) |-> (cons), msg)

// Next-cycle implication.
`define PEGATE_ASSERT_NEXT(label, cond, cons, msg) \
    `PEGATE_ASSERT(label, (cond) |=> (cons), msg)

`endif

/* rtl/pegate_pkg.sv */
// ----------------------------------------------------------------------------
// Peak envelope noise gate package
// Widths, register indexes, reset values and shared types of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pegate_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS     = 24;
    localparam int CHAN_BITS     = 1;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam int CHANNELS_DEF  = 2;

    // Gain is Q1.COEF_BITS, unity is 2^COEF_BITS.
    localparam int GAIN_BITS = COEF_BITS + 1;
    localparam logic [GAIN_BITS-1:0] UNITY = {1'b1, {COEF_BITS{1'b0}}};

    // Shared multiplier: signed A (sample or zero-extended coefficient),
    // signed B (zero-extended envelope, gain operand or gain step).
    localparam int MUL_A_BITS = SAMPLE_BITS + 1;
    localparam int MUL_B_BITS = GAIN_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    localparam logic [COEF_BITS-1:0]   ENV_REL_RST   = COEF_BITS'(16770227);
    localparam logic [COEF_BITS-1:0]   GAIN_ATT_RST  = COEF_BITS'(16603360);
    localparam logic [COEF_BITS-1:0]   GAIN_REL_RST  = COEF_BITS'(16770227);
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = SAMPLE_BITS'(83886);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ENV_RELEASE  = 2'd0,
        REG_GAIN_ATTACK  = 2'd1,
        REG_GAIN_RELEASE = 2'd2,
        REG_THRESHOLD    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [COEF_BITS-1:0]   env_release_coef;
        logic [COEF_BITS-1:0]   gain_attack_coef;
        logic [COEF_BITS-1:0]   gain_release_coef;
        logic [SAMPLE_BITS-1:0] open_threshold;
    } pegate_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_GAIN,
        ST_OUTM,
        ST_FIN
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the input item
        logic env_mul;   // envelope times its decay
        logic gain_mul;  // envelope update, gate decision, gain smoothing
        logic out_mul;   // gain update, sample times gain step
        logic finish;    // load the result register
    } pegate_cmd_t;

endpackage

/* rtl/pegate_if.sv */
// ----------------------------------------------------------------------------
// Peak envelope noise gate channels
// Valid/ready interfaces for input items, result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pegate_in_if import pegate_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [CHAN_BITS-1:0]          chan_in;

    modport source (output valid, output sample_in, output chan_in, input ready);
    modport sink (input valid, input sample_in, input chan_in, output ready);
endinterface

interface pegate_out_if import pegate_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [CHAN_BITS-1:0]          chan_out;
    logic                          gate_open;

    modport source (output valid, output sample_out, output chan_out,
                    output gate_open, input ready);
    modport sink (input valid, input sample_out, input chan_out,
                  input gate_open, output ready);
endinterface

interface pegate_cfg_if import pegate_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/pegate_regs.sv */
// ----------------------------------------------------------------------------
// Peak envelope noise gate configuration registers
// Decodes register writes and holds the coefficients and the threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pegate_regs import pegate_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pegate_cfg_if.sink  cfg,
    output pegate_cfg_t regs
);

    pegate_cfg_t regs_reg;

    // Writes are always taken at once.
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.env_release_coef  <= ENV_REL_RST;
            regs_reg.gain_attack_coef  <= GAIN_ATT_RST;
            regs_reg.gain_release_coef <= GAIN_REL_RST;
            regs_reg.open_threshold    <= THRESHOLD_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_ENV_RELEASE:  regs_reg.env_release_coef  <= COEF_BITS'(cfg.data);
                REG_GAIN_ATTACK:  regs_reg.gain_attack_coef  <= COEF_BITS'(cfg.data);
                REG_GAIN_RELEASE: regs_reg.gain_release_coef <= COEF_BITS'(cfg.data);
                REG_THRESHOLD:    regs_reg.open_threshold    <= SAMPLE_BITS'(cfg.data);
                default:          regs_reg                   <= regs_reg;
            endcase
        end
    end

endmodule

/* rtl/pegate_dp.sv */
// ----------------------------------------------------------------------------
// Peak envelope noise gate datapath
// Per-channel state, one shared multiplier and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pegate_dp import pegate_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pegate_cmd_t                   cmd,
    input  pegate_cfg_t                   regs,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [CHAN_BITS-1:0]          chan_in,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [CHAN_BITS-1:0]          chan_out,
    output logic                          gate_open
);

    logic [SAMPLE_BITS-1:0] env_reg  [CHANNELS];
    logic [GAIN_BITS-1:0]   gain_reg [CHANNELS];

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [CHAN_BITS-1:0]          chan_reg;
    logic                          open_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;

    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic [CHAN_BITS-1:0]          chan_out_reg;
    logic                          gate_open_reg;

    logic                          chan_ok;
    logic [SAMPLE_BITS-1:0]        env_sel;
    logic [GAIN_BITS-1:0]          gain_sel;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [SAMPLE_BITS-1:0]        env_dec;
    logic [SAMPLE_BITS-1:0]        env_new;
    logic                          open_now;
    logic [GAIN_BITS-1:0]          gain_cur;
    logic [COEF_BITS-1:0]          coef;
    logic [GAIN_BITS-1:0]          gain_opnd;
    logic [COEF_BITS-1:0]          step;
    logic [GAIN_BITS-1:0]          gain_new;
    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   mul_p;
    logic signed [PROD_BITS-1:0]   sample_scaled;
    logic signed [PROD_BITS-1:0]   y_full;

    assign chan_ok = (int'(chan_reg) < CHANNELS);

    always_comb
    begin
        env_sel  = '0;
        gain_sel = UNITY;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (int'(chan_reg) == c)
            begin
                env_sel  = env_reg[c];
                gain_sel = gain_reg[c];
            end
        end
    end

    // The magnitude of the most negative sample wraps to itself, which reads
    // correctly as an unsigned value.
    assign mag = sample_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_reg)
                                           : SAMPLE_BITS'(sample_reg);

    // Envelope and gate decision, valid while the gain product is formed.
    assign env_dec  = prod_reg[COEF_BITS +: SAMPLE_BITS];
    assign env_new  = (mag > env_dec) ? mag : env_dec;
    assign open_now = (env_new >= regs.open_threshold);
    assign gain_cur = gain_sel[GAIN_BITS-1] ? UNITY : gain_sel;
    assign coef     = (open_now && (gain_cur < UNITY)) ? regs.gain_attack_coef
                                                       : regs.gain_release_coef;
    // Opening moves the distance to unity, closing moves the gain itself.
    assign gain_opnd = open_now ? (UNITY - gain_cur) : gain_cur;

    // Gain step after smoothing; below unity, so it fits COEF_BITS.
    assign step     = prod_reg[COEF_BITS +: COEF_BITS];
    assign gain_new = open_reg ? (UNITY - {1'b0, step}) : {1'b0, step};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.env_mul)
        begin
            mul_a = MUL_A_BITS'({1'b0, regs.env_release_coef});
            mul_b = MUL_B_BITS'({1'b0, env_sel});
        end
        else if (cmd.gain_mul)
        begin
            mul_a = MUL_A_BITS'({1'b0, coef});
            mul_b = MUL_B_BITS'({1'b0, gain_opnd});
        end
        else if (cmd.out_mul)
        begin
            mul_a = MUL_A_BITS'(sample_reg);
            mul_b = MUL_B_BITS'({1'b0, step});
        end
    end

    assign mul_p = mul_a * mul_b;

    // An open gate multiplies by unity minus the step: s*U - s*step.
    assign sample_scaled = PROD_BITS'(sample_reg) <<< COEF_BITS;
    assign y_full        = open_reg ? (sample_scaled - prod_reg) : prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                env_reg[c]  <= '0;
                gain_reg[c] <= UNITY;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (chan_ok && (int'(chan_reg) == c))
                begin
                    if (cmd.gain_mul)
                    begin
                        env_reg[c] <= env_new;
                    end
                    if (cmd.out_mul)
                    begin
                        gain_reg[c] <= gain_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sample_reg <= sample_in;
            chan_reg   <= chan_in;
        end
        if (cmd.env_mul || cmd.gain_mul || cmd.out_mul)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.gain_mul)
        begin
            open_reg <= open_now && chan_ok;
        end
        if (cmd.finish)
        begin
            sample_out_reg <= chan_ok ? y_full[COEF_BITS +: SAMPLE_BITS] : sample_reg;
            chan_out_reg   <= chan_reg;
            gate_open_reg  <= open_reg;
        end
    end

    assign sample_out = sample_out_reg;
    assign chan_out   = chan_out_reg;
    assign gate_open  = gate_open_reg;

endmodule

/* rtl/pegate_ctrl.sv */
// ----------------------------------------------------------------------------
// Peak envelope noise gate controller
// Sequences the shared multiplier and owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "peak_envelope_noise_gate_top_assert.svh"

module pegate_ctrl import pegate_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output pegate_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        in_fire;

    // The result register can take a new item when empty or being emptied.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_FIN) && out_free);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_ENV;
            ST_ENV:  state_next = ST_GAIN;
            ST_GAIN: state_next = ST_OUTM;
            ST_OUTM: state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = in_fire ? ST_ENV : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.latch      = in_fire;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: ;
            ST_ENV:  cmd.env_mul  = 1'b1;
            ST_GAIN: cmd.gain_mul = 1'b1;
            ST_OUTM: cmd.out_mul  = 1'b1;
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `PEGATE_ASSERT_NEXT(a_accept_starts_env, in_fire, state_reg == ST_ENV, "accepted item did not start the envelope step")
    `PEGATE_ASSERT_NEXT(a_finish_shows_result, (state_reg == ST_FIN) && out_free, out_valid_reg, "finished item not shown as a result")
    `PEGATE_ASSERT_IMPL(a_result_from_finish, $rose(out_valid_reg), $past(state_reg == ST_FIN), "result appeared without a finish step")

endmodule

/* rtl/peak_envelope_noise_gate_top.sv */
// Items are handled one at a time: the single shared multiplier runs
// envelope decay, gain smoothing and output scaling in turn, then the result
// register loads while the next item is taken in that same cycle; both wait
// while the result register still holds an item that is not taken.
// Reset: registers take their defaults, every envelope clears to zero and
// every gain returns to unity at once; items are taken right after reset.
// ----------------------------------------------------------------------------
// Peak envelope noise gate
// Per-channel gate with a decaying peak envelope and a smoothed gate gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peak_envelope_noise_gate_top import pegate_pkg::*;
#(
    // Number of channels with their own envelope and gain state.
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    pegate_in_if.sink    item,
    pegate_out_if.source result,
    pegate_cfg_if.sink   cfg
);

    // Each item moves through four steps:
    //   envelope step: old envelope times its decay coefficient.
    //   gain step:     the new envelope is the larger of the decayed value and
    //                  the sample magnitude; the gate opens when it reaches the
    //                  threshold, and the gain (or its distance to unity) is
    //                  multiplied by the attack or release coefficient.
    //   output step:   the new gain is stored and the sample is multiplied by
    //                  the smoothing step.
    //   finish step:   the gated sample is formed, floored, and loaded into the
    //                  result register, which holds it until it is taken.
    // An item whose channel has no state passes through unchanged with the
    // gate shown closed, and leaves every channel's state alone.

    pegate_cfg_t regs;
    pegate_cmd_t cmd;

    pegate_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pegate_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    pegate_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .regs       (regs),
        .sample_in  (item.sample_in),
        .chan_in    (item.chan_in),
        .sample_out (result.sample_out),
        .chan_out   (result.chan_out),
        .gate_open  (result.gate_open)
    );

endmodule

/* test/tb_peak_envelope_noise_gate_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the peak envelope noise gate
// Drives sample items on both channels and writes the gate registers under
// several settings and idling patterns. A scoreboard class tracks envelope
// and gain per channel, and each result item is compared with what it predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_peak_envelope_noise_gate_top;

    import pegate_pkg::*;

    // Watchdog on the whole run. The slowest correct run stays far below it.
    localparam int CYCLE_LIMIT   = 200000;
    // Cycles to wait after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 8;
    // Length of the long receiver hold-off in the back-pressure phase.
    localparam int HOLD_CYCLES   = 300;
    // Random items per phase. Five phases give roughly 950 items.
    localparam int PHASE_ITEMS   = 190;
    // Only this many mismatches are printed. Later ones are only counted.
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;

    // One gated result item as the block should produce it.
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CHAN_BITS-1:0]          chan;
        logic                          open;
    } gated_item_t;

    // Scoreboard. It keeps its own copy of the registers and of the envelope
    // and gain of each channel. For every accepted item it queues the gated
    // result that the block must return.
    class gate_scoreboard;
        logic [COEF_BITS-1:0]   env_release;
        logic [COEF_BITS-1:0]   gain_attack;
        logic [COEF_BITS-1:0]   gain_release;
        logic [SAMPLE_BITS-1:0] threshold;
        logic [SAMPLE_BITS-1:0] envelope [CHANNELS_DEF];
        logic [GAIN_BITS-1:0]   gain [CHANNELS_DEF];
        gated_item_t            gated_q [$];
        int                     mismatches;

        function new();
            env_release  = ENV_REL_RST;
            gain_attack  = GAIN_ATT_RST;
            gain_release = GAIN_REL_RST;
            threshold    = THRESHOLD_RST;
            foreach (envelope[c])
            begin
                envelope[c] = '0;
                gain[c]     = UNITY;
            end
            mismatches = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_ENV_RELEASE:  env_release  = value;
                REG_GAIN_ATTACK:  gain_attack  = value;
                REG_GAIN_RELEASE: gain_release = value;
                REG_THRESHOLD:    threshold    = value;
                default:          ;
            endcase
        endfunction

        // Envelope update, gate decision, gain smoothing and output scaling
        // for one accepted sample item.
        function void take_sample(logic signed [SAMPLE_BITS-1:0] s,
                                  logic [CHAN_BITS-1:0] ch);
            gated_item_t                    want;
            logic [SAMPLE_BITS-1:0]         mag;
            logic [SAMPLE_BITS-1:0]         env_next;
            logic [2*COEF_BITS-1:0]         decayed;
            logic [GAIN_BITS-1:0]           g;
            logic [COEF_BITS-1:0]           coef;
            logic [COEF_BITS+GAIN_BITS-1:0] scaled;
            logic                           open;
            longint                         prod;

            // The most negative sample has magnitude 2^23, which fits unsigned.
            mag = s;
            if (s[SAMPLE_BITS-1])
                mag = ~mag + 1'b1;
            decayed  = envelope[ch] * env_release;
            env_next = decayed[2*COEF_BITS-1:COEF_BITS];
            if (mag > env_next)
                env_next = mag;
            envelope[ch] = env_next;

            open = (env_next >= threshold);
            g = gain[ch];
            if (g > UNITY)
                g = UNITY;
            // Attack only while the gain still has to rise toward unity.
            coef = (open && g < UNITY) ? gain_attack : gain_release;
            if (open)
            begin
                scaled = coef * (UNITY - g);
                g = UNITY - scaled[COEF_BITS +: GAIN_BITS];
            end
            else
            begin
                scaled = coef * g;
                g = scaled[COEF_BITS +: GAIN_BITS];
            end
            gain[ch] = g;

            prod = longint'(s) * longint'(g);
            want.sample = SAMPLE_BITS'(prod >>> COEF_BITS);
            want.chan   = ch;
            want.open   = open;
            gated_q.push_back(want);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void match_gated(logic signed [SAMPLE_BITS-1:0] s,
                                  logic [CHAN_BITS-1:0] ch, logic open);
            gated_item_t want;

            if (gated_q.size() == 0)
            begin
                note_mismatch($sformatf("result with no item pending: sample %0d chan %0d open %0b",
                                        s, ch, open));
                return;
            end
            want = gated_q.pop_front();
            if (want.sample !== s || want.chan !== ch || want.open !== open)
                note_mismatch($sformatf(
                    "expected sample %0d chan %0d open %0b, got sample %0d chan %0d open %0b",
                    want.sample, want.chan, want.open, s, ch, open));
        endfunction
    endclass

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic rx_hold = 1'b0;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    int   cycle_count  = 0;
    bit   loud         = 1'b0;

    gate_scoreboard sb;

    pegate_in_if  in_ch ();
    pegate_out_if out_ch ();
    pegate_cfg_if cfg_ch ();

    peak_envelope_noise_gate_top #(
        .CHANNELS (CHANNELS_DEF)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog. A hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side. Values are read at the edge before any nonblocking update,
    // so an item counts as taken exactly when valid and ready were both high.
    // Ready is held low in reset; afterwards it is drawn from the stall rate
    // of the phase, unless the long hold-off is in force.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.match_gated(out_ch.sample_out, out_ch.chan_out, out_ch.gate_open);
        if (rx_hold || !rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(1, 100) > rx_stall_pct);
    end

    // Offers one sample item and returns at the edge that accepted it. Valid
    // stays high on return, so back-to-back items never lower and raise it in
    // the same time step. Within this task it is dropped only when a gap is drawn.
    task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s,
                             input logic [CHAN_BITS-1:0] ch);
        if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(1, 100) <= tx_idle_pct)
                @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        in_ch.chan_in   <= ch;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.take_sample(s, ch);
    endtask

    // One register write. Valid stays high so that a run of writes is
    // continuous; load_settings drops it after the last one.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_register(idx, value);
    endtask

    // Writes all four registers. It is called only while the block is idle.
    task automatic load_settings(input int unsigned env_rel, input int unsigned att,
                                 input int unsigned rel, input int unsigned thr);
        write_reg(REG_ENV_RELEASE, CFG_DATA_BITS'(env_rel));
        write_reg(REG_GAIN_ATTACK, CFG_DATA_BITS'(att));
        write_reg(REG_GAIN_RELEASE, CFG_DATA_BITS'(rel));
        write_reg(REG_THRESHOLD, CFG_DATA_BITS'(thr));
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops offering items, waits for every predicted result and then gives
    // the pipeline a few cycles more so that nothing is still in flight.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.gated_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Random sample. Full-range noise makes every bit toggle. Quiet samples,
    // samples right around the threshold, and loud and quiet bursts make the
    // gate open and close, so the gain runs both attack and release.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int                     mag;
        bit                     from_mag;
        logic [SAMPLE_BITS-1:0] raw;

        if ($urandom_range(0, 19) == 0)
            loud = !loud;
        from_mag = 1'b1;
        mag = 0;
        raw = '0;
        case ($urandom_range(0, 15))
            0, 1, 2, 3:
            begin
                from_mag = 1'b0;
                raw = SAMPLE_BITS'($urandom());
            end
            4, 5, 6, 7:
                mag = $urandom_range(0, 255);
            8, 9, 10:
                mag = int'(sb.threshold) + $urandom_range(0, 4) - 2;
            11:
            begin
                from_mag = 1'b0;
                case ($urandom_range(0, 4))
                    0:       raw = S_MAX;
                    1:       raw = S_MIN;
                    2:       raw = '0;
                    3:       raw = 24'd1;
                    default: raw = '1;
                endcase
            end
            default:
                mag = loud ? $urandom_range(1 << 20, (1 << 23) - 1) : $urandom_range(0, 15);
        endcase
        if (from_mag)
        begin
            if (mag < 0)
                mag = 0;
            if (mag > (1 << 23))
                mag = 1 << 23;
            if ($urandom_range(0, 1) == 1)
                raw = SAMPLE_BITS'(-mag);
            else
                raw = SAMPLE_BITS'((mag > S_MAX) ? int'(S_MAX) : mag);
        end
        return signed'(raw);
    endfunction

    task automatic run_random(input int count);
        repeat (count)
            send_item(pick_sample(), CHAN_BITS'($urandom()));
    endtask

    initial
    begin
        sb = new();
        in_ch.valid      <= 1'b0;
        in_ch.sample_in  <= '0;
        in_ch.chan_in    <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_ENV_RELEASE;
        cfg_ch.data      <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items with the reset settings: full-scale samples of both
        // signs, zero and unit steps, and a sample exactly at the threshold.
        send_item(S_MAX, 1'b0);
        send_item(S_MIN, 1'b0);
        send_item(24'sd0, 1'b1);
        send_item(24'sd1, 1'b1);
        send_item(-24'sd1, 1'b1);
        send_item(24'sd83886, 1'b1);
        send_item(24'sd83885, 1'b0);
        send_item(S_MIN, 1'b1);
        drain();

        // Zero threshold keeps the gate open. Zero coefficients make the
        // envelope follow the sample and the gain jump straight to unity.
        load_settings(0, 0, 0, 0);
        send_item(S_MIN, 1'b0);
        send_item(24'sd12345, 1'b1);
        send_item(24'sd0, 1'b0);
        send_item(-24'sd777, 1'b1);
        drain();

        // A threshold above every envelope never opens the gate, and the
        // largest coefficients give the slowest decay of envelope and gain.
        load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_item(S_MAX, 1'b0);
        send_item(S_MIN, 1'b1);
        send_item(S_MIN, 1'b0);
        send_item(24'sd5, 1'b1);
        drain();

        // With the threshold at 2^23 only the most negative sample opens the
        // gate; its magnitude has to be held exactly by the envelope.
        load_settings(0, 24'h800000, 24'h800000, 24'h800000);
        send_item(S_MIN, 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(S_MIN, 1'b1);
        send_item(24'sd100, 1'b1);
        drain();

        // Random phase, reset settings, no idling on either side.
        load_settings(ENV_REL_RST, GAIN_ATT_RST, GAIN_REL_RST, THRESHOLD_RST);
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        run_random(PHASE_ITEMS);
        drain();

        // Random settings, sender idle most of the time.
        load_settings($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1 << 20));
        tx_idle_pct = 63;
        rx_stall_pct <= 0;
        run_random(PHASE_ITEMS);
        drain();

        // Largest coefficients and threshold at 2^23, receiver stalling.
        load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h800000);
        tx_idle_pct = 0;
        rx_stall_pct <= 63;
        run_random(PHASE_ITEMS);
        drain();

        // Coefficients close to one and a low threshold, both sides idling.
        load_settings($urandom_range(24'hF00000, 24'hFFFFFF),
                      $urandom_range(24'hF00000, 24'hFFFFFF),
                      $urandom_range(24'hF00000, 24'hFFFFFF), $urandom_range(0, 1 << 16));
        tx_idle_pct = 34;
        rx_stall_pct <= 34;
        run_random(PHASE_ITEMS);
        drain();

        // Back pressure: the receiver holds off for a long stretch while the
        // sender keeps offering items, so the block fills and stalls its input.
        load_settings(0, 0, 0, $urandom_range(0, 1 << 22));
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                rx_hold <= 1'b0;
            end
            run_random(PHASE_ITEMS);
        join
        drain();

        if (sb.mismatches == 0 && sb.gated_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
